[hw/rtl/itok_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package itok_pkg;

	localparam int unsigned MAX_RES = 3;
	localparam int unsigned CNT_W   = $clog2(MAX_RES + 1);
	localparam int unsigned IDX_W   = $clog2(MAX_RES);
	localparam int unsigned NUM_W   = 31;

	localparam logic [NUM_W-1:0] NUM_MAX = '1;

	// character codes
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_STAR  = 8'h2A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_GT    = 8'h3E;

	typedef enum logic [2:0] {
		PH_START,
		PH_NUM_EMPTY,
		PH_NUM_DIGITS,
		PH_OP,
		PH_STOPPED
	} phase_t;

	// operator characters seen so far
	typedef enum logic [3:0] {
		OPS_EMPTY = 4'd0,
		OPS_ADD   = 4'd1,
		OPS_SUB   = 4'd2,
		OPS_MUL   = 4'd3,
		OPS_DIV   = 4'd4,
		OPS_LT    = 4'd5,
		OPS_GT    = 4'd6,
		OPS_SHL   = 4'd7,
		OPS_SHR   = 4'd8,
		OPS_BAD   = 4'd9
	} opsf_t;

	typedef enum logic [2:0] {
		KIND_NUM       = 3'd0,
		KIND_OP        = 3'd1,
		KIND_NO_OP     = 3'd2,
		KIND_BAD_OP    = 3'd3,
		KIND_BAD_START = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_SHL = 3'd4,
		OP_SHR = 3'd5
	} opcode_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       is_end;
	} char_word_t;

	typedef struct packed {
		kind_t            token_kind;
		logic [NUM_W-1:0] number_value;
		opcode_t          operator_code;
		logic             last_of_run;
	} token_word_t;

	// results of one character, in order from slot 0
	typedef struct packed {
		token_word_t [MAX_RES-1:0] tok;
		logic [CNT_W-1:0]          cnt;
	} group_t;

	function automatic token_word_t mk_tok(kind_t kind, logic [NUM_W-1:0] val, opcode_t op);
		token_word_t t;
		t.token_kind    = kind;
		t.number_value  = val;
		t.operator_code = op;
		t.last_of_run   = 1'b0;
		return t;
	endfunction

endpackage

`default_nettype wire

[hw/rtl/itok_chan_if.sv]
`timescale 1ns / 1ps
`default_nettype none

interface itok_chan_if #(parameter type payload_t = logic) ();
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

[hw/rtl/itok_core.sv]
`timescale 1ns / 1ps
`default_nettype none

module itok_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	itok_chan_if.sink           char_chan,
	input  wire logic           emit_free,
	output itok_pkg::group_t    grp,
	output logic                grp_load
);
	import itok_pkg::*;

	logic              valid_s1;
	char_word_t        word_s1;
	phase_t            phase_q, phase_d;
	logic [NUM_W-1:0]  acc_q, acc_d;
	opsf_t             opsf_q, opsf_d;

	logic              advance;
	logic              is_digit, is_space;
	logic [3:0]        digit;
	logic [NUM_W+3:0]  mac;
	logic [NUM_W-1:0]  acc_sat;
	token_word_t       fin_tok;
	logic              fin_ok;
	token_word_t       num_tok, noop_tok, zero_tok;
	opsf_t             adv_empty, adv_cur;

	function automatic opsf_t op_adv(opsf_t sofar, logic [7:0] c);
		opsf_t r;
		r = OPS_BAD;
		if (sofar == OPS_EMPTY) begin
			case (c)
				CH_PLUS:  r = OPS_ADD;
				CH_MINUS: r = OPS_SUB;
				CH_STAR:  r = OPS_MUL;
				CH_SLASH: r = OPS_DIV;
				CH_LT:    r = OPS_LT;
				CH_GT:    r = OPS_GT;
				default:  r = OPS_BAD;
			endcase
		end else if (sofar == OPS_LT && c == CH_LT) begin
			r = OPS_SHL;
		end else if (sofar == OPS_GT && c == CH_GT) begin
			r = OPS_SHR;
		end
		return r;
	endfunction

	// advance the held word once its results fit in the serializer
	assign advance        = valid_s1 && (grp.cnt == '0 || emit_free);
	assign char_chan.ready = !valid_s1 || advance;
	assign grp_load       = advance && grp.cnt != '0;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (char_chan.ready) begin
			valid_s1 <= char_chan.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (char_chan.ready && char_chan.valid) begin
			word_s1 <= char_chan.payload;
		end
	end

	// scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_START;
			acc_q   <= '0;
			opsf_q  <= OPS_EMPTY;
		end else if (advance) begin
			phase_q <= phase_d;
			acc_q   <= acc_d;
			opsf_q  <= opsf_d;
		end
	end

	// classify the character and extend the number
	assign is_digit  = word_s1.ch >= CH_ZERO && word_s1.ch <= CH_NINE;
	assign is_space  = word_s1.ch inside {CH_SPACE, CH_TAB, CH_NL};
	assign digit     = word_s1.ch[3:0];
	assign mac       = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + (NUM_W+4)'(digit);
	assign acc_sat   = (mac > (NUM_W+4)'(NUM_MAX)) ? NUM_MAX : mac[NUM_W-1:0];
	assign adv_empty = op_adv(OPS_EMPTY, word_s1.ch);
	assign adv_cur   = op_adv(opsf_q, word_s1.ch);

	assign num_tok  = mk_tok(KIND_NUM, acc_q, OP_ADD);
	assign noop_tok = mk_tok(KIND_NO_OP, '0, OP_ADD);
	assign zero_tok = mk_tok(KIND_NUM, '0, OP_ADD);

	// close the operator run
	always_comb begin
		fin_tok = mk_tok(KIND_BAD_OP, '0, OP_ADD);
		case (opsf_q)
			OPS_EMPTY: fin_tok = noop_tok;
			OPS_ADD:   fin_tok = mk_tok(KIND_OP, '0, OP_ADD);
			OPS_SUB:   fin_tok = mk_tok(KIND_OP, '0, OP_SUB);
			OPS_MUL:   fin_tok = mk_tok(KIND_OP, '0, OP_MUL);
			OPS_DIV:   fin_tok = mk_tok(KIND_OP, '0, OP_DIV);
			OPS_SHL:   fin_tok = mk_tok(KIND_OP, '0, OP_SHL);
			OPS_SHR:   fin_tok = mk_tok(KIND_OP, '0, OP_SHR);
			default:   fin_tok = mk_tok(KIND_BAD_OP, '0, OP_ADD);
		endcase
		fin_ok = fin_tok.token_kind == KIND_OP;
	end

	// next state and results of the held word
	always_comb begin
		phase_d = phase_q;
		acc_d   = acc_q;
		opsf_d  = opsf_q;
		grp.tok = '{default: zero_tok};
		grp.cnt = '0;
		if (word_s1.is_end) begin
			case (phase_q)
				PH_START: begin
					grp.tok[0] = mk_tok(KIND_BAD_START, '0, OP_ADD);
					grp.cnt    = CNT_W'(1);
				end
				PH_NUM_EMPTY, PH_NUM_DIGITS: begin
					grp.tok[0] = num_tok;
					grp.tok[1] = noop_tok;
					grp.cnt    = CNT_W'(2);
				end
				PH_OP: begin
					grp.tok[0] = fin_tok;
					if (fin_ok) begin
						grp.tok[1] = zero_tok;
						grp.tok[2] = noop_tok;
						grp.cnt    = CNT_W'(3);
					end else begin
						grp.cnt = CNT_W'(1);
					end
				end
				default: grp.cnt = '0;
			endcase
			phase_d = PH_START;
			acc_d   = '0;
			opsf_d  = OPS_EMPTY;
		end else begin
			case (phase_q)
				PH_START: begin
					if (is_digit) begin
						acc_d   = NUM_W'(digit);
						phase_d = PH_NUM_DIGITS;
					end else begin
						grp.tok[0] = mk_tok(KIND_BAD_START, '0, OP_ADD);
						grp.cnt    = CNT_W'(1);
						phase_d    = PH_STOPPED;
					end
				end
				PH_NUM_EMPTY, PH_NUM_DIGITS: begin
					if (is_digit) begin
						acc_d   = acc_sat;
						phase_d = PH_NUM_DIGITS;
					end else if (is_space) begin
						if (phase_q == PH_NUM_DIGITS) begin
							grp.tok[0] = num_tok;
							grp.cnt    = CNT_W'(1);
							acc_d      = '0;
							opsf_d     = OPS_EMPTY;
							phase_d    = PH_OP;
						end
					end else begin
						grp.tok[0] = num_tok;
						grp.cnt    = CNT_W'(1);
						acc_d      = '0;
						opsf_d     = adv_empty;
						phase_d    = PH_OP;
					end
				end
				PH_OP: begin
					if (is_digit) begin
						grp.tok[0] = fin_tok;
						grp.cnt    = CNT_W'(1);
						if (fin_ok) begin
							acc_d   = NUM_W'(digit);
							phase_d = PH_NUM_DIGITS;
						end else begin
							phase_d = PH_STOPPED;
						end
					end else if (is_space) begin
						if (opsf_q != OPS_EMPTY) begin
							grp.tok[0] = fin_tok;
							grp.cnt    = CNT_W'(1);
							if (fin_ok) begin
								acc_d   = '0;
								phase_d = PH_NUM_EMPTY;
							end else begin
								phase_d = PH_STOPPED;
							end
						end
					end else begin
						opsf_d = adv_cur;
					end
				end
				default: phase_d = phase_q;
			endcase
			// drop the partial token on a stop
			if (phase_d == PH_STOPPED) begin
				acc_d  = '0;
				opsf_d = OPS_EMPTY;
			end
		end
	end

endmodule

`default_nettype wire

[hw/rtl/itok_emit.sv]
`timescale 1ns / 1ps
`default_nettype none

module itok_emit (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             grp_load,
	input  wire itok_pkg::group_t grp,
	output logic                  emit_free,
	itok_chan_if.source           token_chan
);
	import itok_pkg::*;

	logic                    valid_q;
	token_word_t [MAX_RES-1:0] tok_q;
	logic [CNT_W-1:0]        cnt_q;
	logic [IDX_W-1:0]        idx_q;
	logic                    go;
	logic                    last;

	assign go        = valid_q && token_chan.ready;
	assign last      = CNT_W'(idx_q) == cnt_q - CNT_W'(1);
	assign emit_free = !valid_q || (go && last);

	// present the current word of the group
	always_comb begin
		token_chan.payload             = tok_q[idx_q];
		token_chan.payload.last_of_run = last;
	end
	assign token_chan.valid = valid_q;

	// hold a group and step through it one word per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else if (grp_load) begin
			valid_q <= 1'b1;
			idx_q   <= '0;
		end else if (go) begin
			if (last) begin
				valid_q <= 1'b0;
			end
			idx_q <= idx_q + IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (grp_load) begin
			tok_q <= grp.tok;
			cnt_q <= grp.cnt;
		end
	end

endmodule

`default_nettype wire

[hw/rtl/infix_expression_tokenizer.sv]
`timescale 1ns / 1ps
`default_nettype none

// Lexer for infix arithmetic text: one character word in, number and operator
// token words out, with stop codes for malformed text and an end word that
// re-arms the scan. While the token channel is ready, a character is taken
// every cycle while it yields at most one token and the serializer emits one
// word per cycle; a character that closes several tokens (up to three, at end
// of text after an operator) holds back the next one until its last token is
// taken. Each token passes the input register and then the serializer register.
module infix_expression_tokenizer (
	input  wire logic clk,
	input  wire logic arst_n,
	itok_chan_if.sink   char_chan,
	itok_chan_if.source token_chan
);
	import itok_pkg::*;

	group_t grp;
	logic   grp_load;
	logic   emit_free;

	itok_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_chan (char_chan),
		.emit_free (emit_free),
		.grp       (grp),
		.grp_load  (grp_load)
	);

	itok_emit u_emit (
		.clk        (clk),
		.arst_n     (arst_n),
		.grp_load   (grp_load),
		.grp        (grp),
		.emit_free  (emit_free),
		.token_chan (token_chan)
	);

endmodule

`default_nettype wire
